FILE: src/rws_pkg.sv
`default_nettype none
package rws_pkg;

  localparam int RWS_DEPTH  = 256;
  localparam int RWS_IDX_W  = $clog2(RWS_DEPTH);
  localparam int RWS_POP_W  = 9;
  localparam int RWS_FIT_W  = 32;
  localparam int RWS_TOT_W  = 40;
  localparam int RWS_FRAC_W = 16;
  localparam int RWS_HALF_W = RWS_TOT_W / 2;
  localparam int RWS_PROD_W = RWS_FRAC_W + RWS_HALF_W;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  typedef logic [RWS_FIT_W-1:0]  fit_t;
  typedef logic [RWS_TOT_W-1:0]  tot_t;
  typedef logic [RWS_FRAC_W-1:0] frac_t;
  typedef logic [RWS_IDX_W-1:0]  idx_t;
  typedef logic [RWS_POP_W-1:0]  pop_t;

endpackage
`default_nettype wire

FILE: src/roulette_wheel_selector.sv
// Roulette wheel selector over a table of 256 fitness values (UQ24.8).
// Input channel (in_valid/in_ready) carries one word: operation, entry_index,
// fitness_value, random_fraction. A write word stores fitness_value at
// entry_index and updates the running total; it gives no result.
// A select word gives one result word on the output channel
// (out_valid/out_ready): selected_index and found.
// A select forms the slice product, done as two 16x20 partial products,
// then scans the table from entry 0, one table entry a cycle through the
// one read port of the fitness memory, until the slice is reached or all
// population_size entries (at most 256) are scanned, and then loads the
// output register.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes population_size; it
// is always ready; write it only while idle; the block does not enforce it.
// Reset clears the total, population_size and a valid bit per table entry,
// so the whole table reads as zero at once; no clearing pass is needed.
// A result waits in the output register while out_ready is low; write words
// are still taken meanwhile, and a new select finishes its scan and holds
// until the pending result has been taken.
`default_nettype none
module roulette_wheel_selector (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            operation,
  input  wire logic [7:0]      entry_index,
  input  wire rws_pkg::fit_t   fitness_value,
  input  wire rws_pkg::frac_t  random_fraction,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           selected_index,
  output logic                 found,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire rws_pkg::pop_t   cfg_data
);
  import rws_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WR   = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]     state;
  pop_t           pop_cfg;
  pop_t           n_eff;
  pop_t           n_q;
  tot_t           total;
  fit_t           mem [RWS_DEPTH];
  logic [RWS_DEPTH-1:0] vld;
  fit_t           rdata;
  logic           rvld;
  fit_t           rfit;
  idx_t           raddr;
  idx_t           wr_idx;
  fit_t           wr_val;
  logic           mem_we;
  idx_t           proc_idx;
  tot_t           sum;
  tot_t           sum_next;
  idx_t           res_idx;
  logic           res_found;
  logic           in_acc;
  logic           sl_done;
  tot_t           slice;
  logic           last;
  logic           out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign n_eff     = (pop_cfg > RWS_POP_W'(RWS_DEPTH)) ? RWS_POP_W'(RWS_DEPTH) : pop_cfg;
  assign rfit      = rvld ? rdata : '0;
  assign sum_next  = sum + RWS_TOT_W'(rfit);
  assign last      = (RWS_POP_W'(proc_idx) + RWS_POP_W'(1)) == n_q;
  assign mem_we    = (state == S_WR);
  assign out_free  = !out_valid || out_ready;

  rws_slice u_slice (
    .clk   (clk),
    .rst   (rst),
    .start (in_acc && operation == OP_SELECT),
    .frac  (random_fraction),
    .total (total),
    .done  (sl_done),
    .slice (slice)
  );

  always_comb begin
    case (state)
      S_IDLE:  raddr = idx_t'(entry_index);
      S_SCAN:  raddr = proc_idx + idx_t'(1);
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_val;
    end
    rdata <= mem[raddr];
    rvld  <= vld[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (mem_we) begin
      vld[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pop_cfg   <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pop_cfg <= cfg_data;
      end
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= (operation == OP_SELECT) ? S_WAIT : S_WR;
          end
        end
        S_WR: begin
          total <= total - RWS_TOT_W'(rfit) + RWS_TOT_W'(wr_val);
          state <= S_IDLE;
        end
        S_WAIT: begin
          if (sl_done) begin
            state <= (n_q == '0) ? S_FIN : S_SCAN;
          end
        end
        S_SCAN: begin
          if (sum_next >= slice || last) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      wr_idx <= idx_t'(entry_index);
      wr_val <= fitness_value;
      n_q    <= n_eff;
    end
    if (state == S_WAIT && sl_done) begin
      proc_idx  <= '0;
      sum       <= '0;
      res_idx   <= '0;
      res_found <= 1'b0;
    end
    if (state == S_SCAN) begin
      if (sum_next >= slice) begin
        res_idx   <= proc_idx;
        res_found <= 1'b1;
      end else if (!last) begin
        proc_idx <= proc_idx + idx_t'(1);
        sum      <= sum_next;
      end
    end
    if (state == S_FIN && out_free) begin
      selected_index <= 8'(res_idx);
      found          <= res_found;
    end
  end

endmodule
`default_nettype wire

FILE: src/rws_slice.sv
`default_nettype none
module rws_slice (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire rws_pkg::frac_t frac,
  input  wire rws_pkg::tot_t  total,
  output logic               done,
  output rws_pkg::tot_t       slice
);
  import rws_pkg::*;

  localparam int PAD_W = RWS_TOT_W - RWS_PROD_W;

  logic [1:0]            phase;
  frac_t                 frac_q;
  tot_t                  tot_q;
  logic [RWS_PROD_W-1:0] p_lo;
  logic [RWS_PROD_W-1:0] p_hi;

  assign p_hi = RWS_PROD_W'(frac_q) * RWS_PROD_W'(tot_q[RWS_TOT_W-1:RWS_HALF_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
      done  <= 1'b0;
    end else begin
      done <= (phase == 2'd2);
      case (phase)
        2'd0: begin
          if (start) begin
            phase <= 2'd1;
          end
        end
        2'd1: begin
          phase <= 2'd2;
        end
        2'd2: begin
          phase <= 2'd0;
        end
        default: begin
          phase <= 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase == 2'd0 && start) begin
      frac_q <= frac;
      tot_q  <= total;
    end
    if (phase == 2'd1) begin
      p_lo <= RWS_PROD_W'(frac_q) * RWS_PROD_W'(tot_q[RWS_HALF_W-1:0]);
    end
    if (phase == 2'd2) begin
      slice <= {p_hi, {PAD_W{1'b0}}}
             + RWS_TOT_W'(p_lo[RWS_PROD_W-1:RWS_FRAC_W]);
    end
  end

endmodule
`default_nettype wire

FILE: src/rws_checker.sv
`default_nettype none
module rws_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       operation,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] selected_index,
  input wire logic       found
);
  import rws_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(selected_index) && $stable(found))
    else $error("stalled result word changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> selected_index == 8'd0)
    else $error("not-found result with nonzero index");

  a_sel_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation == OP_SELECT |=> !in_ready ##1 !in_ready)
    else $error("select word did not hold the input side");

  a_wr_two: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation == OP_WRITE |=> !in_ready ##1 in_ready)
    else $error("write word did not take two cycles");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind roulette_wheel_selector rws_checker u_rws_checker (.*);
`default_nettype wire
